// File: hdl/chained_hash_table_defines.svh
// ---------------------------------------------------------------------------
// chained_hash_table_defines: assertion macros
// Shared assertion forms for the hash table engine.
// ---------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_DEFINES_SVH
`define CHAINED_HASH_TABLE_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define CHT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/cht_pkg.sv
// ---------------------------------------------------------------------------
// cht_pkg: shared types and constants
// Command and status codes, defaults and the controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none
package cht_pkg;

  localparam int CHT_BUCKETS = 1024;
  localparam int CHT_POOL    = 1024;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_ERASE    = 3'd1;
  localparam logic [2:0] CMD_CONTAINS = 3'd2;
  localparam logic [2:0] CMD_GET_INS  = 3'd3;
  localparam logic [2:0] CMD_CLEAR    = 3'd4;

  localparam logic [1:0] ST_TRUE  = 2'd0;
  localparam logic [1:0] ST_FALSE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mod_step;
    logic       clr_init;
    logic       clr_step;
    logic       head_rd;
    logic       cur_from_head;
    logic       node_rd;
    logic       advance;
    logic       unlink;
    logic       release_node;
    logic       fl_rd;
    logic       take_free;
    logic       take_unused;
    logic       write_node;
    logic       attach;
    logic       out_load;
    logic       out_use_val;
    logic [1:0] out_status;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       mod_done;
    logic       clr_done;
    logic       cur_null;
    logic       match;
    logic       free_valid;
    logic       unused_avail;
  } sts_t;

endpackage
`default_nettype wire

// File: hdl/cht_ram.sv
// ---------------------------------------------------------------------------
// cht_ram: generic simple dual-port RAM
// One write port, one read port with registered, enabled read data.
// ---------------------------------------------------------------------------
`default_nettype none
module cht_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/cht_dp.sv
// ---------------------------------------------------------------------------
// cht_dp: hash table datapath
// Bucket remainder unit, chain pointers, free list, tables and result word.
// ---------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_table_defines.svh"
module cht_dp #(
  parameter int BUCKETS = cht_pkg::CHT_BUCKETS,
  parameter int POOL    = cht_pkg::CHT_POOL
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cht_pkg::ctl_t ctl,
  output cht_pkg::sts_t      sts,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [63:0]   in_key,
  input  wire logic [31:0]   in_value,
  output logic [1:0]         out_status,
  output logic [31:0]        out_read_value,
  output logic [10:0]        out_entry_count
);

  localparam int BW  = $clog2(BUCKETS);
  localparam int NW  = $clog2(POOL);
  localparam int CW  = $clog2(POOL + 1);
  localparam int CXW = CW + 11;
  localparam int NY  = BW + 16;
  localparam logic [NW:0] NIL = {1'b1, {NW{1'b0}}};
  // reciprocal of BUCKETS, exact quotient for any NY-bit dividend
  localparam logic [63:0] MREC64 =
    ((64'd1 << (NY + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [NY:0]  MREC = MREC64[NY:0];
  localparam logic [16:0]  BK   = 17'(BUCKETS);

  logic [2:0]    cmd_r;
  logic [63:0]   key_r;
  logic [31:0]   val_r;
  logic [63:0]   ksh_r;
  logic [BW-1:0] rem_r;
  logic [2:0]    mcnt_r;
  logic [NY-1:0] y_r;
  logic [2*NY:0] prod_r;
  logic [BW-1:0] clr_cnt_r;
  logic [NW:0]   cur_r, prev_r, n_r, free_r;
  logic [CW-1:0] unused_r, count_r;
  logic [1:0]    ostat_r;
  logic [31:0]   oval_r;
  logic [10:0]   ocnt_r;

  logic [NW:0]   head_q, link_q;
  logic [95:0]   node_q;
  logic          prev_null;
  logic          clr_last;
  logic [CXW-1:0] cnt_ext;
  logic [NY-1:0] ynow;
  logic [16:0]   quo;
  logic [33:0]   qb;
  logic [NY-1:0] rdiff;

  function automatic logic is_nan(input logic [63:0] k);
    return k[62:0] > 63'h7FF0_0000_0000_0000;
  endfunction

  function automatic logic key_eq(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] o;
    o = a | b;
    return !is_nan(a) && !is_nan(b) && ((o[62:0] == 63'd0) || (a == b));
  endfunction

  // key mod BUCKETS, Horner over four 16-bit digits, MSB first; each digit
  // takes a reciprocal multiply step, then a subtract quotient * BUCKETS step
  assign ynow  = {rem_r, ksh_r[63:48]};
  assign quo   = prod_r[2*NY:NY+BW];
  assign qb    = {17'd0, quo} * {17'd0, BK};
  assign rdiff = y_r - qb[NY-1:0];

  assign prev_null = prev_r[NW];
  assign clr_last  = (clr_cnt_r == BW'(BUCKETS - 1));
  assign cnt_ext   = CXW'(count_r);

  always_comb begin
    sts.cmd          = cmd_r;
    sts.mod_done     = (mcnt_r == 3'd7);
    sts.clr_done     = clr_last;
    sts.cur_null     = cur_r[NW];
    sts.match        = key_eq(node_q[63:0], key_r);
    sts.free_valid   = !free_r[NW];
    sts.unused_avail = (unused_r < CW'(POOL));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      free_r    <= NIL;
      unused_r  <= '0;
      count_r   <= '0;
    end else begin
      if (ctl.clr_step) begin
        clr_cnt_r <= clr_last ? '0 : clr_cnt_r + BW'(1);
      end
      if (ctl.clr_init) begin
        free_r   <= NIL;
        unused_r <= '0;
        count_r  <= '0;
      end
      if (ctl.release_node) begin
        free_r  <= cur_r;
        count_r <= count_r - CW'(1);
      end
      if (ctl.take_free) begin
        free_r <= link_q;
      end
      if (ctl.take_unused) begin
        unused_r <= unused_r + CW'(1);
      end
      if (ctl.attach) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_cmd;
      key_r  <= in_key;
      val_r  <= in_value;
      ksh_r  <= in_key;
      rem_r  <= '0;
      mcnt_r <= '0;
    end
    if (ctl.mod_step) begin
      if (!mcnt_r[0]) begin
        y_r    <= ynow;
        prod_r <= {{(NY + 1){1'b0}}, ynow} * {{NY{1'b0}}, MREC};
      end else begin
        rem_r <= rdiff[BW-1:0];
        ksh_r <= {ksh_r[47:0], 16'd0};
      end
      mcnt_r <= mcnt_r + 3'd1;
    end
    if (ctl.cur_from_head) begin
      cur_r  <= head_q;
      prev_r <= NIL;
    end
    if (ctl.advance) begin
      prev_r <= cur_r;
      cur_r  <= link_q;
    end
    if (ctl.take_free) begin
      n_r <= free_r;
    end
    if (ctl.take_unused) begin
      n_r <= {1'b0, unused_r[NW-1:0]};
    end
    if (ctl.out_load) begin
      ostat_r <= ctl.out_status;
      oval_r  <= ctl.out_use_val ? node_q[95:64] : 32'd0;
      ocnt_r  <= cnt_ext[10:0];
    end
  end

  // bucket heads
  logic          h_we;
  logic [BW-1:0] h_waddr;
  logic [NW:0]   h_wdata;
  assign h_we    = ctl.clr_step || ((ctl.unlink || ctl.attach) && prev_null);
  assign h_waddr = ctl.clr_step ? clr_cnt_r : rem_r;
  assign h_wdata = ctl.clr_step ? NIL : (ctl.unlink ? link_q : n_r);

  cht_ram #(.W(NW + 1), .D(BUCKETS)) u_head (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(ctl.head_rd), .raddr(rem_r), .rdata(head_q)
  );

  // node links
  logic          l_we;
  logic [NW:0]   l_waddr, l_wdata;
  always_comb begin
    l_we    = ctl.write_node || ctl.release_node ||
              ((ctl.unlink || ctl.attach) && !prev_null);
    l_waddr = prev_r;
    l_wdata = n_r;
    if (ctl.write_node) begin
      l_waddr = n_r;
      l_wdata = NIL;
    end else if (ctl.release_node) begin
      l_waddr = cur_r;
      l_wdata = free_r;
    end else if (ctl.unlink) begin
      l_wdata = link_q;
    end
  end

  logic [NW:0] l_raddr;
  assign l_raddr = ctl.fl_rd ? free_r : cur_r;

  cht_ram #(.W(NW + 1), .D(POOL)) u_link (
    .clk(clk), .we(l_we), .waddr(l_waddr[NW-1:0]), .wdata(l_wdata),
    .re(ctl.node_rd || ctl.fl_rd), .raddr(l_raddr[NW-1:0]), .rdata(link_q)
  );

  // node key and value
  logic [31:0] wval;
  assign wval = (cmd_r == cht_pkg::CMD_GET_INS) ? 32'd0 : val_r;

  cht_ram #(.W(96), .D(POOL)) u_node (
    .clk(clk), .we(ctl.write_node), .waddr(n_r[NW-1:0]), .wdata({wval, key_r}),
    .re(ctl.node_rd), .raddr(cur_r[NW-1:0]), .rdata(node_q)
  );

  assign out_status      = ostat_r;
  assign out_read_value  = oval_r;
  assign out_entry_count = ocnt_r;

  `CHT_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(POOL), "entry count above pool size")
  `CHT_ASSERT_IMPL(a_take_unused, ctl.take_unused, unused_r < CW'(POOL), "pool overrun")
  `CHT_ASSERT_IMPL(a_write_valid, ctl.write_node, !n_r[NW], "write to null node")
  `CHT_ASSERT_IMPL(a_release_live, ctl.release_node, count_r != '0 && !cur_r[NW],
                   "release with no live entry")

endmodule
`default_nettype wire

// File: hdl/cht_ctrl.sv
// ---------------------------------------------------------------------------
// cht_ctrl: hash table controller
// Sequences remainder, chain walk, unlink, allocation, clear and response.
// ---------------------------------------------------------------------------
`default_nettype none
module cht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  input  wire cht_pkg::sts_t sts,
  output cht_pkg::ctl_t      ctl
);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_DEC  = 15'b000000000000010,
    S_MOD  = 15'b000000000000100,
    S_HRD  = 15'b000000000001000,
    S_HWT  = 15'b000000000010000,
    S_NRD  = 15'b000000000100000,
    S_NWT  = 15'b000000001000000,
    S_ERA  = 15'b000000010000000,
    S_REL  = 15'b000000100000000,
    S_FLR  = 15'b000001000000000,
    S_FLW  = 15'b000010000000000,
    S_WRN  = 15'b000100000000000,
    S_ATT  = 15'b001000000000000,
    S_CLR  = 15'b010000000000000,
    S_INIT = 15'b100000000000000
  } state_t;

  // response handoff happens from S_IDLE's predecessor states via resp_r
  state_t     state_r, state_nxt;
  logic       resp_r, resp_nxt;
  logic [1:0] rstat_r, rstat_nxt;
  logic       ruse_r, ruse_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    resp_nxt  = resp_r;
    rstat_nxt = rstat_r;
    ruse_nxt  = ruse_r;
    in_tready = 1'b0;

    // pending result moves into the output word once it is free
    if (resp_r && (!out_valid_r || out_tready)) begin
      ctl.out_load    = 1'b1;
      ctl.out_status  = rstat_r;
      ctl.out_use_val = ruse_r;
      resp_nxt        = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_tready = !resp_r;
        if (in_tvalid && !resp_r) begin
          ctl.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        ruse_nxt = 1'b0;
        case (sts.cmd)
          cht_pkg::CMD_INSERT, cht_pkg::CMD_ERASE,
          cht_pkg::CMD_CONTAINS, cht_pkg::CMD_GET_INS: begin
            state_nxt = S_MOD;
          end
          cht_pkg::CMD_CLEAR: begin
            ctl.clr_init = 1'b1;
            state_nxt    = S_CLR;
          end
          default: begin
            rstat_nxt = cht_pkg::ST_FALSE;
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MOD: begin
        ctl.mod_step = 1'b1;
        if (sts.mod_done) begin
          state_nxt = S_HRD;
        end
      end
      S_HRD: begin
        ctl.head_rd = 1'b1;
        state_nxt   = S_HWT;
      end
      S_HWT: begin
        ctl.cur_from_head = 1'b1;
        state_nxt         = S_NRD;
      end
      S_NRD: begin
        if (sts.cur_null) begin
          if (sts.cmd == cht_pkg::CMD_INSERT || sts.cmd == cht_pkg::CMD_GET_INS) begin
            if (sts.free_valid) begin
              state_nxt = S_FLR;
            end else if (sts.unused_avail) begin
              ctl.take_unused = 1'b1;
              state_nxt       = S_WRN;
            end else begin
              rstat_nxt = cht_pkg::ST_FULL;
              resp_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            rstat_nxt = cht_pkg::ST_FALSE;
            resp_nxt  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ctl.node_rd = 1'b1;
          state_nxt   = S_NWT;
        end
      end
      S_NWT: begin
        if (sts.match) begin
          case (sts.cmd)
            cht_pkg::CMD_ERASE: begin
              state_nxt = S_ERA;
            end
            cht_pkg::CMD_INSERT: begin
              rstat_nxt = cht_pkg::ST_FALSE;
              resp_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
            default: begin
              rstat_nxt = cht_pkg::ST_TRUE;
              ruse_nxt  = (sts.cmd == cht_pkg::CMD_GET_INS);
              resp_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          endcase
        end else begin
          ctl.advance = 1'b1;
          state_nxt   = S_NRD;
        end
      end
      S_ERA: begin
        ctl.unlink = 1'b1;
        state_nxt  = S_REL;
      end
      S_REL: begin
        ctl.release_node = 1'b1;
        rstat_nxt        = cht_pkg::ST_TRUE;
        resp_nxt         = 1'b1;
        state_nxt        = S_IDLE;
      end
      S_FLR: begin
        ctl.fl_rd = 1'b1;
        state_nxt = S_FLW;
      end
      S_FLW: begin
        ctl.take_free = 1'b1;
        state_nxt     = S_WRN;
      end
      S_WRN: begin
        ctl.write_node = 1'b1;
        state_nxt      = S_ATT;
      end
      S_ATT: begin
        ctl.attach = 1'b1;
        rstat_nxt  = cht_pkg::ST_TRUE;
        resp_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_CLR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) begin
          rstat_nxt = cht_pkg::ST_TRUE;
          resp_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_INIT: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (ctl.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      resp_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      resp_r      <= resp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rstat_r <= rstat_nxt;
    ruse_r  <= ruse_nxt;
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// File: hdl/chained_hash_table.sv
// ---------------------------------------------------------------------------
// chained_hash_table: separate-chaining hash table engine
// Double keys, signed 32-bit values, bounded node pool, one result per word.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one command word per accepted beat (cmd, key, value).
//   out_* : one result word per command (status, read_value, entry_count).
//   One command is processed at a time. Each command runs through decode,
//   the bucket remainder (a reciprocal multiply and a subtract per 16-bit
//   key digit), a head read, a node read per chain node visited, a check
//   at the chain end, and unlink or allocation, then its result moves into
//   the output register. Chain walk and the remainder unit set the rate.
//   Clear sweeps all bucket heads, one per cycle.
//   After reset the bucket heads are swept to null;
//   in_tready stays low until that ends.
//   A finished result sits in the output register until taken; the next
//   command may run meanwhile, and its result waits (holding in_tready low)
//   while the output register is still full.
// ---------------------------------------------------------------------------
`default_nettype none
module chained_hash_table #(
  parameter int BUCKETS = cht_pkg::CHT_BUCKETS,
  parameter int POOL    = cht_pkg::CHT_POOL
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [103:0] in_tdata,   // cmd[2:0], key[66:3], value[98:67]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [47:0]       out_tdata   // status[1:0], read_value[33:2], entry_count[44:34]
);

  cht_pkg::ctl_t ctl;
  cht_pkg::sts_t sts;
  logic [1:0]    status;
  logic [31:0]   read_value;
  logic [10:0]   entry_count;

  cht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .sts(sts), .ctl(ctl)
  );

  cht_dp #(.BUCKETS(BUCKETS), .POOL(POOL)) u_dp (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .sts(sts),
    .in_cmd(in_tdata[2:0]), .in_key(in_tdata[66:3]), .in_value(in_tdata[98:67]),
    .out_status(status), .out_read_value(read_value), .out_entry_count(entry_count)
  );

  assign out_tdata = {3'b000, entry_count, read_value, status};

endmodule
`default_nettype wire
